// ===== rtl/core/rpf_pkg.sv =====
// Package for the resistor presence and filter unit.
// Shared constants, presence and status codes, configuration and divider control record types.
// No dependencies.
`timescale 1ns / 1ps
package rpf_pkg;
  localparam int unsigned MedianTapsDef   = 5;
  localparam int unsigned AdcFullScaleDef = 4095;
  localparam int unsigned ResW   = 30;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 20;
  localparam logic [ResW-1:0] ResMax = '1;
  localparam logic [ResW-1:0] OneOhm = 30'd256;

  localparam logic [1:0] StMeasuring = 2'd0;
  localparam logic [1:0] StReady     = 2'd1;
  localparam logic [1:0] StNoComp    = 2'd2;

  localparam logic [1:0] PrUnknown = 2'd0;
  localparam logic [1:0] PrPresent = 2'd1;
  localparam logic [1:0] PrAbsent  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgOpenThr    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPresThr    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOpenCnt    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPresCnt    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPresMs     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOutMs      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRefOhms    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgRailMargin = 3'd7;

  typedef struct packed {
    logic [11:0] open_thr;
    logic [11:0] pres_thr;
    logic [3:0]  open_cnt;
    logic [7:0]  pres_cnt;
    logic [15:0] pres_ms;
    logic [15:0] out_ms;
    logic [19:0] ref_ohms;
    logic [7:0]  rail;
  } cfg_t;

  // divider request/response
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== rtl/core/rpf_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rpf_pkg.
`timescale 1ns / 1ps
module rpf_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  import rpf_pkg::*;
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/resistor_presence_and_filter_unit.sv =====
// Top level of the resistor presence and filter unit: presence machine,
// median window, serial divider and filter sequencer. Uses rpf_pkg, rpf_divider.
//
// channel  dir  fields (low bit up)
// s_axis   in   tdata: adc_sample[11:0], now_ms[43:12]
// m_axis   out  tdata: status[1:0], resistance_q8[31:2]
// cfg      in   wr_en_i, wr_idx_i, wr_data_i
//
// A measured request runs presence step, window load, median sort (one compare-swap
// per cycle), rail check, serial divider if in range, averaging and debounce; a new
// request is accepted only once the last result is loaded. Presence-only requests
// skip to the output. Reset asynchronously clears control and filter state and loads
// the default configuration; divider data is not reset. The result sits in an output
// register; a stalled output holds the next result in the last stage.
`timescale 1ns / 1ps
module resistor_presence_and_filter_unit #(
  parameter int unsigned MedianTaps   = rpf_pkg::MedianTapsDef,
  parameter int unsigned AdcFullScale = rpf_pkg::AdcFullScaleDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // adc_sample[11:0], now_ms[43:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[1:0], resistance_q8[31:2]
  input  logic                         wr_en_i,
  input  logic [rpf_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [rpf_pkg::CfgW-1:0]     wr_data_i
);
  import rpf_pkg::*;
  localparam int unsigned FsW  = $clog2(AdcFullScale + 1);
  localparam int unsigned MedW = (FsW > CodeW) ? FsW : CodeW;
  localparam int unsigned IdxW = $clog2(MedianTaps);
  localparam int unsigned FilW = $clog2(MedianTaps + 1);
  localparam int unsigned NumW = 20 + FsW + 8;
  localparam logic [FsW-1:0] FullScale = FsW'(AdcFullScale);

  typedef enum logic [3:0] {
    S_IDLE, S_PRES, S_LOAD, S_SORT, S_RAIL, S_DIV, S_WAITDIV, S_AVG1, S_AVG2,
    S_AVG3, S_DB, S_OUT
  } state_e;

  state_e state_q;
  cfg_t cfg_q;
  logic [1:0] presence_q;
  logic [3:0] open_count_q;
  logic [7:0] present_count_q;
  logic [TimeW-1:0] present_since_q, change_since_q, now_q;
  logic [CodeW-1:0] code_q;
  logic [CodeW-1:0] win_q [MedianTaps];
  logic [CodeW-1:0] tmp_q [MedianTaps];
  logic [IdxW-1:0] widx_q, sidx_q;
  logic [FilW-1:0] fill_q;
  logic [FilW-1:0] pass_q;
  logic [ResW-1:0] avg_q, stable_q, raw_q, res_q;
  logic avg_v_q, stable_v_q, pend_q, up_q;
  logic [1:0] status_q;
  logic out_v_q;
  logic [31:0] m_data_q;
  logic out_load;
  logic [CodeW-1:0] med_q;
  logic [FsW-1:0] room_q;
  logic [ResW+3:0] d_q;
  logic div_start, div_busy, div_done;
  logic [NumW-1:0] quo;

  logic [CodeW-1:0] adc_in;
  logic [TimeW-1:0] now_in;
  assign adc_in = s_axis_tdata[11:0];
  assign now_in = s_axis_tdata[43:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{open_thr: 12'd4075, pres_thr: 12'd4060, open_cnt: 4'd3,
                 pres_cnt: 8'd5, pres_ms: 16'd200, out_ms: 16'd300,
                 ref_ohms: 20'd10000, rail: 8'd12};
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        CfgOpenThr:    cfg_q.open_thr <= wr_data_i[11:0];
        CfgPresThr:    cfg_q.pres_thr <= wr_data_i[11:0];
        CfgOpenCnt:    cfg_q.open_cnt <= wr_data_i[3:0];
        CfgPresCnt:    cfg_q.pres_cnt <= wr_data_i[7:0];
        CfgPresMs:     cfg_q.pres_ms  <= wr_data_i[15:0];
        CfgOutMs:      cfg_q.out_ms   <= wr_data_i[15:0];
        CfgRefOhms:    cfg_q.ref_ohms <= wr_data_i;
        CfgRailMargin: cfg_q.rail     <= wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign div_start = (state_q == S_DIV);
  rpf_divider #(.NumW(NumW), .DenW(FsW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({cfg_q.ref_ohms, 8'd0} * NumW'(med_q)),
    .den_i(room_q), .busy_o(div_busy), .done_o(div_done), .quo_o(quo)
  );

  logic [ResW+3:0] avg_denom;
  logic [TimeW-1:0] cdiff;
  assign avg_denom = (avg_q < OneOhm) ? (ResW+4)'(OneOhm) : (ResW+4)'(avg_q);
  assign cdiff = now_q - change_since_q;

  assign out_load = (state_q == S_OUT) && (!out_v_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0; m_data_q <= '0;
    end else if (out_load) begin
      out_v_q <= 1'b1; m_data_q <= {res_q, status_q};
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; presence_q <= PrUnknown; open_count_q <= '0;
      present_count_q <= '0; present_since_q <= '0; change_since_q <= '0;
      widx_q <= '0; fill_q <= '0; avg_q <= '0; stable_q <= '0;
      avg_v_q <= 1'b0; stable_v_q <= 1'b0; pend_q <= 1'b0; up_q <= 1'b0;
      status_q <= StMeasuring; res_q <= '0;
      sidx_q <= '0; pass_q <= '0;
      code_q <= '0; now_q <= '0; med_q <= '0; room_q <= '0; raw_q <= '0; d_q <= '0;
      for (int i = 0; i < MedianTaps; i++) win_q[i] <= '0;
      for (int i = 0; i < MedianTaps; i++) tmp_q[i] <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          code_q <= adc_in; now_q <= now_in; state_q <= S_PRES;
        end
        S_PRES: begin
          state_q <= S_OUT;
          if (presence_q == PrUnknown) begin
            if (code_q >= cfg_q.open_thr) begin
              present_count_q <= '0; present_since_q <= '0;
              if ((open_count_q < cfg_q.open_cnt ? open_count_q + 4'd1 : open_count_q)
                  >= cfg_q.open_cnt) begin
                presence_q <= PrAbsent; res_q <= '0; status_q <= StNoComp;
                widx_q <= '0; fill_q <= '0; avg_v_q <= 1'b0; stable_v_q <= 1'b0;
                avg_q <= '0; stable_q <= '0;
                pend_q <= 1'b0; up_q <= 1'b0; change_since_q <= '0;
                for (int i = 0; i < MedianTaps; i++) win_q[i] <= '0;
              end else status_q <= StMeasuring;
              if (open_count_q < cfg_q.open_cnt) open_count_q <= open_count_q + 4'd1;
            end else if (code_q <= cfg_q.pres_thr) begin
              open_count_q <= '0;
              if (((present_count_q < {4'd0, cfg_q.open_cnt}) ?
                   present_count_q + 8'd1 : present_count_q) >= {4'd0, cfg_q.open_cnt}) begin
                presence_q <= PrPresent; present_count_q <= '0; state_q <= S_LOAD;
              end else begin
                status_q <= StMeasuring;
                if (present_count_q < {4'd0, cfg_q.open_cnt})
                  present_count_q <= present_count_q + 8'd1;
              end
            end else begin
              open_count_q <= '0; present_count_q <= '0; status_q <= StMeasuring;
            end
          end else if (presence_q == PrPresent) begin
            if (code_q >= cfg_q.open_thr) begin
              if (open_count_q < cfg_q.open_cnt) open_count_q <= open_count_q + 4'd1;
              if ((open_count_q < cfg_q.open_cnt ? open_count_q + 4'd1 : open_count_q)
                  >= cfg_q.open_cnt) begin
                presence_q <= PrAbsent; present_count_q <= '0; present_since_q <= '0;
                res_q <= '0; status_q <= StNoComp;
                widx_q <= '0; fill_q <= '0; avg_v_q <= 1'b0; stable_v_q <= 1'b0;
                avg_q <= '0; stable_q <= '0;
                pend_q <= 1'b0; up_q <= 1'b0; change_since_q <= '0;
                for (int i = 0; i < MedianTaps; i++) win_q[i] <= '0;
              end
            end else begin
              open_count_q <= '0; state_q <= S_LOAD;
            end
          end else begin
            status_q <= StNoComp; res_q <= '0;
            if (code_q <= cfg_q.pres_thr) begin
              logic [TimeW-1:0] since;
              logic [7:0] pc;
              since = (present_count_q == 8'd0) ? now_q : present_since_q;
              pc = (present_count_q != 8'hFF) ? present_count_q + 8'd1 : present_count_q;
              if (pc >= cfg_q.pres_cnt && (now_q - since) >= {16'd0, cfg_q.pres_ms}) begin
                presence_q <= PrPresent; present_count_q <= '0; open_count_q <= '0;
                present_since_q <= '0;
                fill_q <= '0; avg_v_q <= 1'b0; stable_v_q <= 1'b0;
                avg_q <= '0; stable_q <= '0;
                pend_q <= 1'b0; up_q <= 1'b0; change_since_q <= '0;
                for (int i = 0; i < MedianTaps; i++) win_q[i] <= '0;
                widx_q <= '0;
                state_q <= S_LOAD;
              end else begin
                present_since_q <= since; present_count_q <= pc;
              end
            end else begin
              present_count_q <= '0; present_since_q <= '0;
            end
          end
        end
        S_LOAD: begin
          win_q[widx_q] <= code_q;
          for (int i = 0; i < MedianTaps; i++)
            tmp_q[i] <= (IdxW'(i) == widx_q) ? code_q : win_q[i];
          widx_q <= (widx_q == IdxW'(MedianTaps - 1)) ? '0 : widx_q + 1'b1;
          if (fill_q < FilW'(MedianTaps)) fill_q <= fill_q + 1'b1;
          sidx_q <= '0; pass_q <= '0;
          state_q <= S_SORT;
        end
        S_SORT: begin
          // bubble passes over the filled entries, one pair per cycle
          if (FilW'(sidx_q) + FilW'(1) < fill_q) begin
            if (tmp_q[sidx_q] > tmp_q[sidx_q + 1'b1]) begin
              tmp_q[sidx_q] <= tmp_q[sidx_q + 1'b1];
              tmp_q[sidx_q + 1'b1] <= tmp_q[sidx_q];
            end
          end
          if (sidx_q == IdxW'(MedianTaps - 2)) begin
            sidx_q <= '0;
            pass_q <= pass_q + 1'b1;
            if (pass_q == FilW'(MedianTaps - 1)) state_q <= S_RAIL;
          end else sidx_q <= sidx_q + 1'b1;
        end
        S_RAIL: begin
          logic [CodeW-1:0] m;
          m = tmp_q[IdxW'(fill_q >> 1)];
          med_q <= m;
          room_q <= FullScale - FsW'(m);
          if (MedW'(m) < MedW'(cfg_q.rail)) begin
            raw_q <= '0; state_q <= S_AVG1;
          end else if (MedW'(m) >= MedW'(FullScale) ||
                       (MedW'(FullScale) - MedW'(m)) < MedW'(cfg_q.rail)) begin
            presence_q <= PrAbsent; present_count_q <= '0; present_since_q <= '0;
            res_q <= '0; status_q <= StNoComp;
            widx_q <= '0; fill_q <= '0; avg_v_q <= 1'b0; stable_v_q <= 1'b0;
            avg_q <= '0; stable_q <= '0;
            pend_q <= 1'b0; up_q <= 1'b0; change_since_q <= '0;
            for (int i = 0; i < MedianTaps; i++) win_q[i] <= '0;
            state_q <= S_OUT;
          end else state_q <= S_DIV;
        end
        S_DIV: state_q <= S_WAITDIV;
        S_WAITDIV: if (div_done) begin
          raw_q <= (quo > NumW'(ResMax)) ? ResMax : quo[ResW-1:0];
          state_q <= S_AVG1;
        end
        S_AVG1: begin
          if (!avg_v_q) begin
            avg_q <= raw_q; avg_v_q <= 1'b1; state_q <= S_DB;
          end else begin
            d_q <= (raw_q > avg_q) ? (ResW+4)'(raw_q - avg_q) : (ResW+4)'(avg_q - raw_q);
            state_q <= S_AVG2;
          end
        end
        S_AVG2: begin
          logic [ResW+5:0] d20;
          d20 = ({2'b00, d_q} << 4) + ({2'b00, d_q} << 2);
          if (d20 >= {2'b00, avg_denom}) d_q <= (d_q << 2) + (d_q << 1) + (ResW+4)'(10);
          else d_q <= d_q + (ResW+4)'(10);
          state_q <= S_AVG3;
        end
        S_AVG3: begin
          // divide by 20: drop two bits, then multiply by the reciprocal of five
          logic [63:0] prod;
          prod = d_q[ResW+3:2] * 32'hCCCC_CCCD;
          if (raw_q > avg_q) avg_q <= avg_q + prod[ResW+33:34];
          else avg_q <= avg_q - prod[ResW+33:34];
          state_q <= S_DB;
        end
        S_DB: begin
          logic [ResW-1:0] dd;
          logic upn;
          dd = (avg_q > stable_q) ? avg_q - stable_q : stable_q - avg_q;
          upn = avg_q > stable_q;
          status_q <= StReady;
          state_q <= S_OUT;
          if (!stable_v_q) begin
            stable_q <= avg_q; stable_v_q <= 1'b1; pend_q <= 1'b0; up_q <= 1'b0;
            res_q <= avg_q;
          end else if (dd <= OneOhm || ({8'd0, dd} * 38'd200) <= {8'd0, stable_q}) begin
            pend_q <= 1'b0; up_q <= 1'b0; change_since_q <= '0; res_q <= stable_q;
          end else if (!pend_q || upn != up_q) begin
            pend_q <= 1'b1; up_q <= upn; change_since_q <= now_q; res_q <= stable_q;
          end else if (cdiff < {16'd0, cfg_q.out_ms}) begin
            res_q <= stable_q;
          end else begin
            stable_q <= avg_q; pend_q <= 1'b0; up_q <= 1'b0; change_since_q <= '0;
            res_q <= avg_q;
          end
        end
        S_OUT: if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = m_data_q;

  logic unused_ok;
  assign unused_ok = div_busy;

  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_WAITDIV) else $error("divider result out of sequence");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready) else $error("ready while busy");
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_data_q[1:0] == StNoComp) |-> m_data_q[31:2] == '0)
    else $error("resistance while absent");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped while stalled");
endmodule
